// File: sv/evpz_pkg.sv
// Shared types and constants for the eased view pan/zoom block.
package evpz_pkg;

   localparam int POS_W   = 19;
   localparam int ZOOM_W  = 18;
   localparam int LIM_W   = 10;
   localparam int ASP_W   = 16;
   localparam int SPAN_W  = 27;
   localparam int TICK_W  = 24;
   localparam int FRAC_Q  = 16;

   localparam logic [SPAN_W-1:0] MAX_SPAN = 27'd99999999;
   localparam logic [POS_W-1:0]  POS_MAX  = 19'h7FFFF;
   localparam logic [FRAC_Q:0]   T_ONE    = 17'h10000;

   localparam logic CMD_FOCUS = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [1:0] REG_MIN_ZOOM = 2'd0;
   localparam logic [1:0] REG_MAX_ZOOM = 2'd1;
   localparam logic [1:0] REG_ASPECT   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic               command;
      logic [POS_W-1:0]   goal_x;
      logic [POS_W-1:0]   goal_y;
      logic signed [15:0] goal_zoom;
      logic signed [31:0] span_time;
      logic [TICK_W-1:0]  tick_time;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  eye_x;
      logic [POS_W-1:0]  eye_y;
      logic [ZOOM_W-1:0] view_zoom;
      logic              arrived;
   } rsp_type;

   // classified word passed from front to back
   typedef struct packed {
      logic              command;
      logic [POS_W-1:0]  aim_x;
      logic [POS_W-1:0]  aim_y;
      logic [LIM_W-1:0]  aim_zoom;
      logic [SPAN_W-1:0] span;
      logic [TICK_W-1:0] tick;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

// File: sv/evpz_fifo.sv
// Short command queue between the front and back sections.
module evpz_fifo
   import evpz_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_data,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type stat
);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign stat.full  = (cnt_ff == QUEUE_DEPTH[QPTR_W:0]);
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QPTR_W{1'b0}}, do_push} - {{QPTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/evpz_front.sv
// Front section: takes request words, clamps focus parameters, queues commands.
module evpz_front
   import evpz_pkg::*;
#(
   parameter int WORLD_SIZE = 2048,
   parameter int FRAC_BITS  = 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic [LIM_W-1:0] min_zoom,
   input  logic [LIM_W-1:0] max_zoom,
   input  logic [ASP_W-1:0] aspect_ratio,
   input  qstat_type        qstat,
   output logic             push,
   output cmd_type          push_data
);

   localparam int PROD_W = LIM_W + ASP_W;
   localparam int HALF_W = PROD_W + FRAC_BITS;
   localparam int PW     = (HALF_W > 34 ? HALF_W : 34) + 2;
   localparam logic signed [PW-1:0] WORLD = PW'(longint'(WORLD_SIZE) << FRAC_BITS);

   typedef enum logic [1:0] {F_IDLE, F_CLAMP, F_PLACE} fstate_type;

   fstate_type          state_ff;
   req_type             item_ff;
   logic [LIM_W-1:0]    zoom_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [LIM_W-1:0]    zoom_in;
   logic signed [15:0]  zoom_lo;
   logic [SPAN_W-1:0]   span_in;
   logic [HALF_W-1:0]   half_x;
   logic signed [PW-1:0] half_xs, half_ys;

   function automatic logic [POS_W-1:0] place(input logic signed [PW-1:0] goal,
                                             input logic signed [PW-1:0] half);
      logic signed [PW-1:0] hi, c;
      hi = WORLD - half;
      if (half > hi) c = WORLD >>> 1;
      else if (goal < half) c = half;
      else if (goal > hi) c = hi;
      else c = goal;
      if (c < 0) c = '0;
      if (c > $signed({{(PW-POS_W){1'b0}}, POS_MAX})) c = {{(PW-POS_W){1'b0}}, POS_MAX};
      return c[POS_W-1:0];
   endfunction

   always_comb begin
      // lower limit first, then upper, so crossed limits resolve to max_zoom
      if ($signed(item_ff.goal_zoom) < $signed({6'b0, min_zoom}))
         zoom_lo = $signed({6'b0, min_zoom});
      else
         zoom_lo = item_ff.goal_zoom;
      if (zoom_lo > $signed({6'b0, max_zoom})) zoom_in = max_zoom;
      else zoom_in = zoom_lo[LIM_W-1:0];
      if (item_ff.span_time < 0) span_in = '0;
      else if (item_ff.span_time > $signed({5'b0, MAX_SPAN})) span_in = MAX_SPAN;
      else span_in = item_ff.span_time[SPAN_W-1:0];
   end

   assign half_x  = HALF_W'({prod_ff, {FRAC_BITS{1'b0}}} >> 12);
   assign half_xs = PW'(half_x);
   assign half_ys = PW'({zoom_ff, {FRAC_BITS{1'b0}}});

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PLACE);

   always_comb begin
      push_data.command  = item_ff.command;
      push_data.aim_x    = place(PW'(item_ff.goal_x), half_xs);
      push_data.aim_y    = place(PW'(item_ff.goal_y), half_ys);
      push_data.aim_zoom = zoom_ff;
      push_data.span     = span_ff;
      push_data.tick     = item_ff.tick_time;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= F_CLAMP;
               end
            end
            F_CLAMP: begin
               zoom_ff  <= zoom_in;
               span_ff  <= span_in;
               prod_ff  <= PROD_W'(zoom_in) * PROD_W'(aspect_ratio);
               state_ff <= F_PLACE;
            end
            F_PLACE: begin
               if (!qstat.full) state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// File: sv/evpz_back.sv
// Back section: view state, serial divider, smoothstep and blend sequencer.
module evpz_back
   import evpz_pkg::*;
#(
   parameter int FRAC_BITS = 8
)
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   head,
   input  qstat_type qstat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   typedef enum logic [2:0] {B_IDLE, B_DIV, B_SQ, B_CUBE, B_MUL, B_ADD, B_EMIT} bstate_type;

   bstate_type         state_ff;
   logic [POS_W-1:0]   aim_x_ff, aim_y_ff, from_x_ff, from_y_ff, view_x_ff, view_y_ff;
   logic [LIM_W-1:0]   aim_zoom_ff;
   logic [ZOOM_W-1:0]  from_zoom_ff, now_zoom_ff, zt;
   logic [SPAN_W-1:0]  elapsed_ff, span_ff, left;
   logic [SPAN_W:0]    el_sum, rem_sh;
   logic               settled_ff, arrived_ff;
   logic [SPAN_W:0]    rem_ff;
   logic [FRAC_Q:0]    p_ff, t_ff, t_in, w;
   logic [3:0]         step_ff;
   logic [2*FRAC_Q+2:0] sq_ff;
   logic [3*FRAC_Q+3:0] cube;
   logic [1:0]         sel_ff;
   logic [POS_W-1:0]   ba, bb;
   logic [POS_W+FRAC_Q:0] ma_ff, mb_ff;
   logic [POS_W+FRAC_Q+1:0] bsum;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   assign zt     = ZOOM_W'({aim_zoom_ff, {FRAC_BITS{1'b0}}});
   assign left   = span_ff - elapsed_ff;
   assign el_sum = {1'b0, elapsed_ff} + (SPAN_W+1)'(head.tick);
   assign rem_sh = {rem_ff[SPAN_W-1:0], 1'b0};
   assign cube   = sq_ff * (18'd196608 - {p_ff, 1'b0});
   assign t_in   = (cube[3*FRAC_Q+3:2*FRAC_Q] > 20'(T_ONE)) ? T_ONE
                                                           : cube[2*FRAC_Q+FRAC_Q:2*FRAC_Q];
   assign w      = T_ONE - t_ff;
   assign bsum   = ma_ff + mb_ff;
   assign pop    = (state_ff == B_IDLE) && !qstat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      unique case (sel_ff)
         2'd0:    begin ba = from_x_ff; bb = aim_x_ff; end
         2'd1:    begin ba = from_y_ff; bb = aim_y_ff; end
         default: begin ba = POS_W'(from_zoom_ff); bb = POS_W'(zt); end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         aim_x_ff     <= '0;
         aim_y_ff     <= '0;
         from_x_ff    <= '0;
         from_y_ff    <= '0;
         view_x_ff    <= '0;
         view_y_ff    <= '0;
         aim_zoom_ff  <= '0;
         from_zoom_ff <= '0;
         now_zoom_ff  <= '0;
         elapsed_ff   <= '0;
         span_ff      <= '0;
         settled_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != B_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (!qstat.empty) begin
                  if (head.command == CMD_FOCUS) begin
                     aim_x_ff     <= head.aim_x;
                     aim_y_ff     <= head.aim_y;
                     aim_zoom_ff  <= head.aim_zoom;
                     from_x_ff    <= view_x_ff;
                     from_y_ff    <= view_y_ff;
                     from_zoom_ff <= now_zoom_ff;
                     elapsed_ff   <= '0;
                     span_ff      <= head.span;
                     settled_ff   <= 1'b0;
                  end else if (!settled_ff) begin
                     if (left < SPAN_W'(head.tick)) begin
                        view_x_ff   <= aim_x_ff;
                        view_y_ff   <= aim_y_ff;
                        now_zoom_ff <= zt;
                        settled_ff  <= 1'b1;
                        arrived_ff  <= 1'b1;
                        state_ff    <= B_EMIT;
                     end else begin
                        elapsed_ff <= el_sum[SPAN_W-1:0];
                        arrived_ff <= 1'b0;
                        if (span_ff == '0 || el_sum[SPAN_W-1:0] >= span_ff) begin
                           p_ff     <= T_ONE;
                           state_ff <= B_SQ;
                        end else begin
                           rem_ff   <= el_sum;
                           p_ff     <= '0;
                           step_ff  <= '0;
                           state_ff <= B_DIV;
                        end
                     end
                  end
               end
            end
            B_DIV: begin
               // restoring divide, one quotient bit per cycle
               if (rem_sh >= {1'b0, span_ff}) begin
                  rem_ff <= rem_sh - {1'b0, span_ff};
                  p_ff   <= {p_ff[FRAC_Q-1:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  p_ff   <= {p_ff[FRAC_Q-1:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd15) state_ff <= B_SQ;
            end
            B_SQ: begin
               sq_ff    <= (2*FRAC_Q+3)'(p_ff) * (2*FRAC_Q+3)'(p_ff);
               state_ff <= B_CUBE;
            end
            B_CUBE: begin
               t_ff     <= t_in;
               sel_ff   <= 2'd0;
               state_ff <= B_MUL;
            end
            B_MUL: begin
               ma_ff    <= ba * w;
               mb_ff    <= bb * t_ff;
               state_ff <= B_ADD;
            end
            B_ADD: begin
               unique case (sel_ff)
                  2'd0:    view_x_ff   <= bsum[POS_W+FRAC_Q-1:FRAC_Q];
                  2'd1:    view_y_ff   <= bsum[POS_W+FRAC_Q-1:FRAC_Q];
                  default: now_zoom_ff <= bsum[ZOOM_W+FRAC_Q-1:FRAC_Q];
               endcase
               sel_ff   <= sel_ff + 1'b1;
               state_ff <= (sel_ff == 2'd2) ? B_EMIT : B_MUL;
            end
            B_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.eye_x     <= view_x_ff;
                  rsp_ff.eye_y     <= view_y_ff;
                  rsp_ff.view_zoom <= now_zoom_ff;
                  rsp_ff.arrived   <= arrived_ff;
                  rsp_valid_ff     <= 1'b1;
                  state_ff         <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// File: sv/eased_view_pan_zoom_core.sv
// Top level of the eased view pan/zoom block with its register port.
// Pans and zooms a view over a square world with smoothstep easing. A focus
// word (command 0) clamps zoom, duration and centre and starts a new move; it
// yields no result. A tick word (command 1) returns one result while a move is
// pending: centre and half-height, with arrived set on the tick that snaps to
// the target. The front clamps each word into a 4-entry queue and stalls
// until it is queued. The back takes a focus when idle; a snapping tick
// goes straight to emit, an eased tick through a 16-step serial divider for
// progress, two multiply steps for easing and a blend multiplier shared by
// x, y and zoom. Registers: 0x0 min_zoom, 0x4 max_zoom, 0x8 aspect_ratio.
module eased_view_pan_zoom_core
   import evpz_pkg::*;
#(
   parameter int WORLD_SIZE = 2048,
   parameter int FRAC_BITS  = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [LIM_W-1:0] min_zoom_ff, max_zoom_ff;
   logic [ASP_W-1:0] aspect_ff;
   logic             wr_en, push, pop;
   cmd_type          push_data, head;
   qstat_type        qstat;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_zoom_ff <= 10'd1;
         max_zoom_ff <= 10'd1023;
         aspect_ff   <= 16'd7282;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_MIN_ZOOM: min_zoom_ff <= pwdata[LIM_W-1:0];
            REG_MAX_ZOOM: max_zoom_ff <= pwdata[LIM_W-1:0];
            REG_ASPECT:   aspect_ff   <= pwdata[ASP_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MIN_ZOOM: prdata = 32'(min_zoom_ff);
         REG_MAX_ZOOM: prdata = 32'(max_zoom_ff);
         REG_ASPECT:   prdata = 32'(aspect_ff);
         default:      prdata = '0;
      endcase
   end

   evpz_front #(.WORLD_SIZE(WORLD_SIZE), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .min_zoom     (min_zoom_ff),
      .max_zoom     (max_zoom_ff),
      .aspect_ratio (aspect_ff),
      .qstat        (qstat),
      .push         (push),
      .push_data    (push_data)
   );

   evpz_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (qstat)
   );

   evpz_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
